### hdl/mcsr_pkg.sv
package mcsr_pkg;

  typedef enum logic [3:0] {
    KIND_READ   = 4'd0,
    KIND_WRITE  = 4'd1,
    KIND_SET    = 4'd2,
    KIND_CLEAR  = 4'd3,
    KIND_TRAP   = 4'd4,
    KIND_TRET   = 4'd5,
    KIND_DENTER = 4'd6,
    KIND_RESUME = 4'd7,
    KIND_TICK   = 4'd8
  } kind_e;

  localparam logic [11:0] CSR_FPFLG    = 12'h001;
  localparam logic [11:0] CSR_FRM      = 12'h002;
  localparam logic [11:0] CSR_FCSR     = 12'h003;
  localparam logic [11:0] CSR_MSTATUS  = 12'h300;
  localparam logic [11:0] CSR_MISA     = 12'h301;
  localparam logic [11:0] CSR_MIE      = 12'h304;
  localparam logic [11:0] CSR_TVEC     = 12'h305;
  localparam logic [11:0] CSR_MCOUNTEN = 12'h306;
  localparam logic [11:0] CSR_MCOUNTIN = 12'h320;
  localparam logic [11:0] CSR_SCRATCH  = 12'h340;
  localparam logic [11:0] CSR_EXCPC    = 12'h341;
  localparam logic [11:0] CSR_MCAUSE   = 12'h342;
  localparam logic [11:0] CSR_MCYC_LO  = 12'hB00;
  localparam logic [11:0] CSR_CYCLE    = 12'hC00;
  localparam logic [11:0] CSR_MCYC_HI  = 12'hB80;
  localparam logic [11:0] CSR_CYCLEH   = 12'hC80;
  localparam logic [11:0] CSR_MRET_LO  = 12'hB02;
  localparam logic [11:0] CSR_INSTRET  = 12'hC02;
  localparam logic [11:0] CSR_MRET_HI  = 12'hB82;
  localparam logic [11:0] CSR_INSTRH   = 12'hC82;
  localparam logic [11:0] CSR_EXTEN    = 12'hBE0;
  localparam logic [11:0] CSR_EXTPEND  = 12'hBE1;
  localparam logic [11:0] CSR_EXTFORCE = 12'hBE2;
  localparam logic [11:0] CSR_EXTCLAIM = 12'hBE4;
  localparam logic [11:0] CSR_EXTCTX   = 12'hBE5;
  localparam logic [11:0] CSR_SLEEP    = 12'hBF0;
  localparam logic [11:0] CSR_TCTRL    = 12'h7A5;
  localparam logic [11:0] CSR_DCSR     = 12'h7B0;
  localparam logic [11:0] CSR_DPC      = 12'h7B1;
  localparam logic [11:0] CSR_DDATA    = 12'hBFF;
  localparam logic [11:0] CSR_MVENDOR  = 12'hF11;
  localparam logic [11:0] CSR_MARCH    = 12'hF12;
  localparam logic [11:0] CSR_MIMP     = 12'hF13;
  localparam logic [11:0] CSR_MHART    = 12'hF14;
  localparam logic [11:0] CSR_MCONFIG  = 12'hF15;

  localparam logic [31:0] MISA_VAL    = 32'h4090_1104;
  localparam logic [11:0] MIE_KEEP    = 12'h777;
  localparam logic [11:0] MIE_WMASK   = 12'h888;
  localparam logic [31:0] VENDOR_VAL  = 32'hace1_ab00;
  localparam logic [31:0] ARCH_VAL    = 32'h0000_001b;
  localparam logic [31:0] IMP_VAL     = 32'hace1_ab01;
  localparam logic [31:0] HART_VAL    = 32'hace1_ab02;
  localparam logic [31:0] CONFIG_VAL  = 32'hace1_ab03;
  localparam logic [31:0] MCAUSE_INT  = 32'h8000_0000;
  localparam logic [31:0] DCSR_BASE   = 32'h4000_0000;

  localparam logic [3:0] IRQ_NONE = 4'd0;
  localparam logic [3:0] IRQ_SW   = 4'd3;
  localparam logic [3:0] IRQ_TMR  = 4'd7;
  localparam logic [3:0] IRQ_EXT  = 4'd11;

  typedef struct packed {
    logic        machine_priv;
    logic [4:0]  status;
    logic [31:0] scratch;
    logic [31:0] vbase;
    logic [31:0] epc;
    logic [11:0] mie;
    logic [1:0]  inhibit;
    logic [63:0] cycles;
    logic [63:0] retired;
    logic [7:0]  fcsr;
    logic [2:0]  counten;
    logic [31:0] ext_en;
    logic [31:0] ext_force;
    logic [7:0]  ext_ctx;
    logic [2:0]  sleep;
    logic [1:0]  trig;
    logic        dbg_mode;
    logic [5:0]  dctrl;
    logic [31:0] dpc;
    logic [31:0] ext_smp;
    logic        sw_smp;
    logic        tmr_smp;
  } csr_state_t;

  localparam csr_state_t ST_RESET = '{
    machine_priv: 1'b1,
    status:       5'b00100,
    inhibit:      2'b11,
    counten:      3'd5,
    ext_ctx:      8'h40,
    default:      '0
  };

  typedef struct packed {
    logic [3:0]  code;
    logic        active;
    logic [4:0]  winner;
    logic        none;
  } irq_info_t;

  function automatic irq_info_t irq_eval(csr_state_t s);
    irq_info_t   r;
    logic [31:0] elig;
    elig     = (s.ext_smp | s.ext_force) & s.ext_en;
    r.none   = (elig == '0);
    r.winner = '0;
    for (int b = 31; b >= 0; b--) begin
      if (elig[b]) r.winner = 5'(b);
    end
    if (!s.ext_ctx[7] && !r.none && s.mie[11]) r.code = IRQ_EXT;
    else if (s.sw_smp && s.mie[3]) r.code = IRQ_SW;
    else if (s.tmr_smp && s.mie[7]) r.code = IRQ_TMR;
    else r.code = IRQ_NONE;
    r.active = (r.code != IRQ_NONE) && (s.status[0] || !s.machine_priv) && !s.dctrl[2];
    return r;
  endfunction

endpackage

### hdl/mcsr_read.sv
module mcsr_read
  import mcsr_pkg::*;
(
  input  csr_state_t  st_i,
  input  irq_info_t   irq_i,
  input  logic [11:0] addr_i,
  input  logic        bank_i,
  input  logic [31:0] ddata_i,
  output logic [31:0] rdata_o
);

  logic [31:0] ext_pend;

  function automatic logic [31:0] half(logic [31:0] v, logic b);
    return b ? {v[31:16], 16'h0} : {v[15:0], 16'h0};
  endfunction

  assign ext_pend = st_i.ext_smp | st_i.ext_force;

  always_comb begin
    unique case (addr_i)
      CSR_FPFLG:    rdata_o = {27'h0, st_i.fcsr[4:0]};
      CSR_FRM:      rdata_o = {29'h0, st_i.fcsr[7:5]};
      CSR_FCSR:     rdata_o = {24'h0, st_i.fcsr};
      CSR_MSTATUS:  rdata_o = {10'h0, st_i.status[4], 3'h0, st_i.status[3], 4'h0,
                               {2{st_i.status[2]}}, 3'h0, st_i.status[1], 3'h0,
                               st_i.status[0], 3'h0};
      CSR_MISA:     rdata_o = MISA_VAL;
      CSR_MIE:      rdata_o = {20'h0, st_i.mie};
      CSR_TVEC:     rdata_o = {st_i.vbase[31:2], 1'b0, st_i.vbase[0]};
      CSR_MCOUNTEN: rdata_o = {29'h0, st_i.counten};
      CSR_MCOUNTIN: rdata_o = {29'h0, st_i.inhibit[1], 1'b0, st_i.inhibit[0]};
      CSR_SCRATCH:  rdata_o = st_i.scratch;
      CSR_EXCPC:    rdata_o = st_i.epc;
      CSR_MCAUSE:   rdata_o = MCAUSE_INT | {28'h0, irq_i.active ? irq_i.code : IRQ_NONE};
      CSR_MCYC_LO, CSR_CYCLE:   rdata_o = st_i.cycles[31:0];
      CSR_MCYC_HI, CSR_CYCLEH:  rdata_o = st_i.cycles[63:32];
      CSR_MRET_LO, CSR_INSTRET: rdata_o = st_i.retired[31:0];
      CSR_MRET_HI, CSR_INSTRH:  rdata_o = st_i.retired[63:32];
      CSR_EXTEN:    rdata_o = half(st_i.ext_en, bank_i);
      CSR_EXTPEND:  rdata_o = half(ext_pend, bank_i);
      CSR_EXTFORCE: rdata_o = half(st_i.ext_force, bank_i);
      CSR_EXTCLAIM: rdata_o = {irq_i.none, 24'h0, irq_i.winner, 2'h0};
      CSR_EXTCTX:   rdata_o = {11'h0, st_i.ext_ctx[7], 4'h0, st_i.ext_ctx[6], 6'h0,
                               st_i.ext_ctx[5:1], 3'h0, st_i.ext_ctx[0]};
      CSR_SLEEP:    rdata_o = {29'h0, st_i.sleep};
      CSR_TCTRL:    rdata_o = {24'h0, st_i.trig[0], 3'h0, st_i.trig[1], 3'h0};
      CSR_DCSR:     rdata_o = DCSR_BASE | {16'h0, st_i.dctrl[0], 2'h0, st_i.dctrl[1],
                               1'b0, 2'b11, st_i.dctrl[5:3], 3'h0, st_i.dctrl[2],
                               {2{st_i.machine_priv}}};
      CSR_DPC:      rdata_o = st_i.dpc;
      CSR_DDATA:    rdata_o = ddata_i;
      CSR_MVENDOR:  rdata_o = VENDOR_VAL;
      CSR_MARCH:    rdata_o = ARCH_VAL;
      CSR_MIMP:     rdata_o = IMP_VAL;
      CSR_MHART:    rdata_o = HART_VAL;
      CSR_MCONFIG:  rdata_o = CONFIG_VAL;
      default:      rdata_o = '0;
    endcase
  end

endmodule

### hdl/mcsr_update.sv
module mcsr_update
  import mcsr_pkg::*;
(
  input  csr_state_t  st_i,
  input  irq_info_t   irq_i,
  input  logic [3:0]  kind_i,
  input  logic [11:0] addr_i,
  input  logic [31:0] op_i,
  input  logic [31:0] tpc_i,
  input  logic [4:0]  cause_i,
  input  logic        is_int_i,
  input  logic [31:0] irq_ext_i,
  input  logic        irq_sw_i,
  input  logic        irq_tmr_i,
  input  logic        retiring_i,
  input  logic [31:0] old_i,
  output csr_state_t  st_o,
  output logic        redir_o,
  output logic [31:0] target_o
);

  logic        allowed;
  logic [31:0] v;
  logic [15:0] vh;

  assign allowed = st_i.machine_priv || st_i.dbg_mode;
  assign vh      = v[31:16];

  always_comb begin
    if (kind_i == KIND_SET) v = old_i | op_i;
    else if (kind_i == KIND_CLEAR) v = old_i & ~op_i;
    else v = op_i;
  end

  always_comb begin
    st_o     = st_i;
    redir_o  = 1'b0;
    target_o = '0;
    case (kind_i)
      KIND_READ: begin
        if (addr_i == CSR_EXTCLAIM && allowed && !irq_i.none)
          st_o.ext_force[irq_i.winner] = 1'b0;
      end
      KIND_WRITE, KIND_SET, KIND_CLEAR: begin
        if (allowed) begin
          case (addr_i)
            CSR_FPFLG:    st_o.fcsr[4:0] = v[4:0];
            CSR_FRM:      st_o.fcsr[7:5] = v[2:0];
            CSR_FCSR:     st_o.fcsr = v[7:0];
            CSR_MSTATUS:  st_o.status = {v[21], v[17], v[12], v[7], v[3]};
            CSR_MIE:      st_o.mie = (st_i.mie & MIE_KEEP) | (v[11:0] & MIE_WMASK);
            CSR_TVEC:     st_o.vbase = {v[31:2], st_i.vbase[1], v[0]};
            CSR_MCOUNTEN: st_o.counten = v[2:0];
            CSR_MCOUNTIN: st_o.inhibit = {v[0], v[2]};
            CSR_SCRATCH:  st_o.scratch = v;
            CSR_EXCPC:    st_o.epc = {v[31:1], 1'b0};
            CSR_MCYC_LO:  st_o.cycles[31:0] = v;
            CSR_MCYC_HI:  st_o.cycles[63:32] = v;
            CSR_MRET_LO:  st_o.retired[31:0] = v;
            CSR_MRET_HI:  st_o.retired[63:32] = v;
            CSR_EXTEN: begin
              if (op_i[0]) st_o.ext_en[31:16] = vh;
              else st_o.ext_en[15:0] = vh;
            end
            CSR_EXTFORCE: begin
              if (op_i[0]) st_o.ext_force[31:16] = vh;
              else st_o.ext_force[15:0] = vh;
            end
            CSR_EXTCLAIM: begin
              if (v[0]) st_o.ext_ctx = {1'b1, irq_i.none, irq_i.winner, st_i.ext_ctx[0]};
            end
            CSR_EXTCTX: begin
              if (kind_i != KIND_CLEAR && op_i[1]) st_o.ext_ctx = 8'h40;
              else begin
                st_o.ext_ctx = {v[20], v[15], v[8:4], v[0]};
                if (v[2]) st_o.mie[3] = 1'b1;
              end
            end
            CSR_SLEEP:    st_o.sleep = v[2:0];
            CSR_TCTRL:    st_o.trig = {v[3], v[7]};
            CSR_DCSR: begin
              if (st_i.dbg_mode) begin
                st_o.dctrl = {st_i.dctrl[5:3], v[2], v[12], v[15]};
                st_o.machine_priv = (v[1:0] != 2'b00);
              end
            end
            CSR_DPC: begin
              if (st_i.dbg_mode) st_o.dpc = {v[31:1], 1'b0};
            end
            default: ;
          endcase
        end
      end
      KIND_TRAP: begin
        st_o.epc          = {tpc_i[31:1], 1'b0};
        st_o.status[2]    = st_i.machine_priv;
        st_o.status[1]    = st_i.status[0];
        st_o.status[0]    = 1'b0;
        st_o.machine_priv = 1'b1;
        st_o.trig         = {st_i.trig[0], 1'b0};
        if (is_int_i && cause_i == 5'd11) st_o.ext_ctx = st_i.ext_ctx | 8'h81;
        redir_o  = 1'b1;
        target_o = {st_i.vbase[31:2], 2'b00} |
                   ((is_int_i && st_i.vbase[0]) ? {25'h0, cause_i, 2'b00} : 32'h0);
      end
      KIND_TRET: begin
        st_o.machine_priv = st_i.status[2];
        st_o.status[0]    = st_i.status[1];
        st_o.status[1]    = 1'b1;
        st_o.status[3]    = st_i.status[2] & st_i.status[3];
        st_o.trig[0]      = st_i.trig[1];
        if (st_i.ext_ctx[0]) st_o.ext_ctx = st_i.ext_ctx & 8'h7e;
        redir_o  = 1'b1;
        target_o = st_i.epc;
      end
      KIND_DENTER: begin
        st_o.dbg_mode   = 1'b1;
        st_o.dpc        = {tpc_i[31:1], 1'b0};
        st_o.dctrl[5:3] = cause_i[2:0];
      end
      KIND_RESUME: begin
        if (st_i.dbg_mode) begin
          st_o.dbg_mode = 1'b0;
          redir_o  = 1'b1;
          target_o = st_i.dpc;
        end
      end
      KIND_TICK: begin
        if (!st_i.inhibit[0] || st_i.dbg_mode) st_o.cycles = st_i.cycles + 64'd1;
        if ((!st_i.inhibit[1] || st_i.dbg_mode) && retiring_i)
          st_o.retired = st_i.retired + 64'd1;
        st_o.ext_smp = irq_ext_i;
        st_o.sw_smp  = irq_sw_i;
        st_o.tmr_smp = irq_tmr_i;
      end
      default: ;
    endcase
  end

endmodule

### hdl/machine_csr_interrupt_unit.sv
// the result strobe comes in the cycle after start is accepted
// throughput: one command per cycle, busy_o is always low
// the state update and result are computed in one pass from the state registers
// reset: all CSR state to defaults, mtvec and the vector base register to zero, no result pending
// here the receiver cannot stall
module machine_csr_interrupt_unit
  import mcsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  kind_i,
  input  logic [11:0] csr_addr_i,
  input  logic [31:0] operand_i,
  input  logic [31:0] trap_pc_i,
  input  logic [4:0]  trap_cause_i,
  input  logic        trap_is_interrupt_i,
  input  logic [31:0] irq_external_i,
  input  logic        irq_software_i,
  input  logic        irq_timer_i,
  input  logic        retiring_i,
  input  logic [31:0] debug_data_in_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic        redirect_o,
  output logic [31:0] redir_pc_o,
  output logic        interrupt_pending_o,
  output logic [3:0]  interrupt_code_o,
  output logic        machine_mode_o,
  output logic        debug_active_o
);

  csr_state_t  st_q, st_d, st_upd;
  irq_info_t   irq_cur, irq_nxt;
  logic [31:0] tvr_q, rdata, target;
  logic        redir, cfg_wr;
  logic        done_q;
  logic [31:0] rd_q, tgt_q;
  logic        redir_q;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? tvr_q : 32'h0;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign busy_o = 1'b0;

  assign irq_cur = irq_eval(st_q);

  mcsr_read u_read (
    .st_i    (st_q),
    .irq_i   (irq_cur),
    .addr_i  (csr_addr_i),
    .bank_i  (operand_i[0]),
    .ddata_i (debug_data_in_i),
    .rdata_o (rdata)
  );

  mcsr_update u_upd (
    .st_i       (st_q),
    .irq_i      (irq_cur),
    .kind_i     (kind_i),
    .addr_i     (csr_addr_i),
    .op_i       (operand_i),
    .tpc_i      (trap_pc_i),
    .cause_i    (trap_cause_i),
    .is_int_i   (trap_is_interrupt_i),
    .irq_ext_i  (irq_external_i),
    .irq_sw_i   (irq_software_i),
    .irq_tmr_i  (irq_timer_i),
    .retiring_i (retiring_i),
    .old_i      (rdata),
    .st_o       (st_upd),
    .redir_o    (redir),
    .target_o   (target)
  );

  always_comb begin
    st_d = st_q;
    if (start_i) st_d = st_upd;
    if (cfg_wr) st_d.vbase = pwdata;
  end

  assign irq_nxt = irq_eval(st_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_RESET;
      tvr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= start_i;
      if (cfg_wr) tvr_q <= pwdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q    <= (kind_i <= KIND_CLEAR) ? rdata : 32'h0;
    redir_q <= redir;
    tgt_q   <= target;
  end

  assign done_o              = done_q;
  assign read_data_o         = rd_q;
  assign redirect_o          = redir_q;
  assign redir_pc_o          = tgt_q;
  assign interrupt_pending_o = irq_nxt.active;
  assign interrupt_code_o    = irq_nxt.active ? irq_nxt.code : IRQ_NONE;
  assign machine_mode_o      = st_q.machine_priv;
  assign debug_active_o      = st_q.dbg_mode;

endmodule

### hdl/mcsr_checker.sv
module mcsr_checker
  import mcsr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [3:0]  kind_i,
  input logic        done_o,
  input logic [31:0] read_data_o,
  input logic        redirect_o,
  input logic [31:0] redir_pc_o,
  input logic        interrupt_pending_o,
  input logic [3:0]  interrupt_code_o,
  input logic        debug_active_o
);

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o) else $error("missing result");

  a_nodone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o) else $error("spurious result");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !interrupt_pending_o |-> interrupt_code_o == IRQ_NONE)
    else $error("code without pending");

  a_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !redirect_o |-> redir_pc_o == 32'h0) else $error("stray target");

  a_dbg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && kind_i == KIND_DENTER) |=> debug_active_o) else $error("debug entry");

endmodule

bind machine_csr_interrupt_unit mcsr_checker u_chk (.*);

### verif/tb.sv
module tb;
  import mcsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]  kind;
    logic [11:0] addr;
    logic [31:0] op;
    logic [31:0] tpc;
    logic [4:0]  cause;
    logic        is_int;
    logic [31:0] ext;
    logic        sw;
    logic        tmr;
    logic        ret;
    logic [31:0] dbg;
  } cmd_t;

  typedef struct {
    logic [31:0] rd;
    logic        redir;
    logic [31:0] target;
    logic        pend;
    logic [3:0]  code;
    logic        mmode;
    logic        dmode;
  } resp_t;

  typedef struct {
    cmd_t        c;
    logic        chk;
    logic [31:0] rd;
  } row_t;

  localparam int WATCHDOG = 2000;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        start_i, busy_o, done_o;
  logic [3:0]  kind_i;
  logic [11:0] csr_addr_i;
  logic [31:0] operand_i, trap_pc_i, irq_external_i, debug_data_in_i;
  logic [4:0]  trap_cause_i;
  logic        trap_is_interrupt_i, irq_software_i, irq_timer_i, retiring_i;
  logic [31:0] read_data_o, redir_pc_o;
  logic        redirect_o, interrupt_pending_o, machine_mode_o, debug_active_o;
  logic [3:0]  interrupt_code_o;

  machine_csr_interrupt_unit u_top (.*);

  csr_state_t  csr_st;
  resp_t       resp_q[$];
  int          fails;
  int          quiet;
  int          idle_pct;

  logic [11:0] csr_list[35] = '{CSR_FPFLG, CSR_FRM, CSR_FCSR, CSR_MSTATUS, CSR_MISA, CSR_MIE,
    CSR_TVEC, CSR_MCOUNTEN, CSR_MCOUNTIN, CSR_SCRATCH, CSR_EXCPC, CSR_MCAUSE, CSR_MCYC_LO,
    CSR_CYCLE, CSR_MCYC_HI, CSR_CYCLEH, CSR_MRET_LO, CSR_INSTRET, CSR_MRET_HI, CSR_INSTRH,
    CSR_EXTEN, CSR_EXTPEND, CSR_EXTFORCE, CSR_EXTCLAIM, CSR_EXTCTX, CSR_SLEEP, CSR_TCTRL,
    CSR_DCSR, CSR_DPC, CSR_DDATA, CSR_MVENDOR, CSR_MARCH, CSR_MIMP, CSR_MHART, CSR_MCONFIG};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // interrupt arbitration
  function automatic logic [31:0] ext_elig();
    return (csr_st.ext_smp | csr_st.ext_force) & csr_st.ext_en;
  endfunction

  function automatic logic [4:0] ext_lowest();
    logic [31:0] e;
    e = ext_elig();
    for (int b = 0; b < 32; b++) begin
      if (e[b]) return 5'(b);
    end
    return 5'd0;
  endfunction

  function automatic logic [3:0] irq_sel();
    if (!csr_st.ext_ctx[7] && ext_elig() != '0 && csr_st.mie[11]) return IRQ_EXT;
    if (csr_st.sw_smp && csr_st.mie[3]) return IRQ_SW;
    if (csr_st.tmr_smp && csr_st.mie[7]) return IRQ_TMR;
    return IRQ_NONE;
  endfunction

  function automatic logic irq_taken();
    return irq_sel() != IRQ_NONE && (csr_st.status[0] || !csr_st.machine_priv) &&
           !csr_st.dctrl[2];
  endfunction

  function automatic logic [31:0] csr_value(logic [11:0] a, logic [31:0] op, logic [31:0] dbg);
    logic [31:0] r;
    r = '0;
    case (a)
      CSR_FPFLG: r = {27'd0, csr_st.fcsr[4:0]};
      CSR_FRM: r = {29'd0, csr_st.fcsr[7:5]};
      CSR_FCSR: r = {24'd0, csr_st.fcsr};
      CSR_MSTATUS: begin
        r[21] = csr_st.status[4];
        r[17] = csr_st.status[3];
        r[12:11] = {2{csr_st.status[2]}};
        r[7] = csr_st.status[1];
        r[3] = csr_st.status[0];
      end
      CSR_MISA: r = MISA_VAL;
      CSR_MIE: r = {20'd0, csr_st.mie};
      CSR_TVEC: r = {csr_st.vbase[31:2], 1'b0, csr_st.vbase[0]};
      CSR_MCOUNTEN: r = {29'd0, csr_st.counten};
      CSR_MCOUNTIN: r = {29'd0, csr_st.inhibit[1], 1'b0, csr_st.inhibit[0]};
      CSR_SCRATCH: r = csr_st.scratch;
      CSR_EXCPC: r = csr_st.epc;
      CSR_MCAUSE: r = MCAUSE_INT | (irq_taken() ? {28'd0, irq_sel()} : 32'd0);
      CSR_MCYC_LO, CSR_CYCLE: r = csr_st.cycles[31:0];
      CSR_MCYC_HI, CSR_CYCLEH: r = csr_st.cycles[63:32];
      CSR_MRET_LO, CSR_INSTRET: r = csr_st.retired[31:0];
      CSR_MRET_HI, CSR_INSTRH: r = csr_st.retired[63:32];
      CSR_EXTEN: r = {op[0] ? csr_st.ext_en[31:16] : csr_st.ext_en[15:0], 16'd0};
      CSR_EXTPEND: begin
        r = csr_st.ext_smp | csr_st.ext_force;
        r = {op[0] ? r[31:16] : r[15:0], 16'd0};
      end
      CSR_EXTFORCE: r = {op[0] ? csr_st.ext_force[31:16] : csr_st.ext_force[15:0], 16'd0};
      CSR_EXTCLAIM: begin
        r[31] = (ext_elig() == '0);
        r[6:2] = ext_lowest();
      end
      CSR_EXTCTX: begin
        r[20] = csr_st.ext_ctx[7];
        r[15] = csr_st.ext_ctx[6];
        r[8:4] = csr_st.ext_ctx[5:1];
        r[0] = csr_st.ext_ctx[0];
      end
      CSR_SLEEP: r = {29'd0, csr_st.sleep};
      CSR_TCTRL: begin
        r[7] = csr_st.trig[0];
        r[3] = csr_st.trig[1];
      end
      CSR_DCSR: begin
        r = DCSR_BASE;
        r[15] = csr_st.dctrl[0];
        r[12] = csr_st.dctrl[1];
        r[10:9] = 2'b11;
        r[8:6] = csr_st.dctrl[5:3];
        r[2] = csr_st.dctrl[2];
        r[1:0] = csr_st.machine_priv ? 2'b11 : 2'b00;
      end
      CSR_DPC: r = csr_st.dpc;
      CSR_DDATA: r = dbg;
      CSR_MVENDOR: r = VENDOR_VAL;
      CSR_MARCH: r = ARCH_VAL;
      CSR_MIMP: r = IMP_VAL;
      CSR_MHART: r = HART_VAL;
      CSR_MCONFIG: r = CONFIG_VAL;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic void csr_update(logic [11:0] a, logic [31:0] op, logic [3:0] kind,
                                     logic [31:0] old);
    logic [31:0] v;
    v = (kind == KIND_SET) ? (old | op) : (kind == KIND_CLEAR) ? (old & ~op) : op;
    case (a)
      CSR_FPFLG: csr_st.fcsr[4:0] = v[4:0];
      CSR_FRM: csr_st.fcsr[7:5] = v[2:0];
      CSR_FCSR: csr_st.fcsr = v[7:0];
      CSR_MSTATUS: csr_st.status = {v[21], v[17], v[12], v[7], v[3]};
      CSR_MIE: csr_st.mie = (csr_st.mie & MIE_KEEP) | (v[11:0] & MIE_WMASK);
      CSR_TVEC: csr_st.vbase = (v & 32'hffff_fffd) | (csr_st.vbase & 32'd2);
      CSR_MCOUNTEN: csr_st.counten = v[2:0];
      CSR_MCOUNTIN: csr_st.inhibit = {v[0], v[2]};
      CSR_SCRATCH: csr_st.scratch = v;
      CSR_EXCPC: csr_st.epc = {v[31:1], 1'b0};
      CSR_MCYC_LO: csr_st.cycles[31:0] = v;
      CSR_MCYC_HI: csr_st.cycles[63:32] = v;
      CSR_MRET_LO: csr_st.retired[31:0] = v;
      CSR_MRET_HI: csr_st.retired[63:32] = v;
      CSR_EXTEN: begin
        if (op[0]) csr_st.ext_en[31:16] = v[31:16];
        else csr_st.ext_en[15:0] = v[31:16];
      end
      CSR_EXTFORCE: begin
        if (op[0]) csr_st.ext_force[31:16] = v[31:16];
        else csr_st.ext_force[15:0] = v[31:16];
      end
      CSR_EXTCLAIM: begin
        if (v[0]) csr_st.ext_ctx = {1'b1, ext_elig() == '0, ext_lowest(), csr_st.ext_ctx[0]};
      end
      CSR_EXTCTX: begin
        if (kind != KIND_CLEAR && op[1]) begin
          csr_st.ext_ctx = 8'h40;
        end else begin
          csr_st.ext_ctx = {v[20], v[15], v[8:4], v[0]};
          if (v[2]) csr_st.mie[3] = 1'b1;
        end
      end
      CSR_SLEEP: csr_st.sleep = v[2:0];
      CSR_TCTRL: csr_st.trig = {v[3], v[7]};
      CSR_DCSR: begin
        if (csr_st.dbg_mode) begin
          csr_st.dctrl = {csr_st.dctrl[5:3], v[2], v[12], v[15]};
          csr_st.machine_priv = |v[1:0];
        end
      end
      CSR_DPC: begin
        if (csr_st.dbg_mode) csr_st.dpc = {v[31:1], 1'b0};
      end
      default: ;
    endcase
  endfunction

  function automatic resp_t csr_step(cmd_t c);
    resp_t r;
    logic  ok;
    logic  mpp;
    r = '{default: '0};
    ok = csr_st.machine_priv || csr_st.dbg_mode;
    case (c.kind)
      KIND_READ: begin
        r.rd = csr_value(c.addr, c.op, c.dbg);
        if (c.addr == CSR_EXTCLAIM && ok && ext_elig() != '0)
          csr_st.ext_force[ext_lowest()] = 1'b0;
      end
      KIND_WRITE, KIND_SET, KIND_CLEAR: begin
        r.rd = csr_value(c.addr, c.op, c.dbg);
        if (ok) csr_update(c.addr, c.op, c.kind, r.rd);
      end
      KIND_TRAP: begin
        csr_st.epc = {c.tpc[31:1], 1'b0};
        csr_st.status[2] = csr_st.machine_priv;
        csr_st.status[1] = csr_st.status[0];
        csr_st.status[0] = 1'b0;
        csr_st.machine_priv = 1'b1;
        csr_st.trig = {csr_st.trig[0], 1'b0};
        if (c.is_int && c.cause == 5'd11) csr_st.ext_ctx |= 8'h81;
        r.redir = 1'b1;
        r.target = {csr_st.vbase[31:2], 2'b00} |
                   ((c.is_int && csr_st.vbase[0]) ? {25'd0, c.cause, 2'b00} : 32'd0);
      end
      KIND_TRET: begin
        mpp = csr_st.status[2];
        csr_st.machine_priv = mpp;
        csr_st.status[0] = csr_st.status[1];
        csr_st.status[1] = 1'b1;
        csr_st.status[3] = mpp & csr_st.status[3];
        csr_st.trig[0] = csr_st.trig[1];
        if (csr_st.ext_ctx[0]) csr_st.ext_ctx &= ~8'h81;
        r.redir = 1'b1;
        r.target = csr_st.epc;
      end
      KIND_DENTER: begin
        csr_st.dbg_mode = 1'b1;
        csr_st.dpc = {c.tpc[31:1], 1'b0};
        csr_st.dctrl = {c.cause[2:0], csr_st.dctrl[2:0]};
      end
      KIND_RESUME: begin
        if (csr_st.dbg_mode) begin
          csr_st.dbg_mode = 1'b0;
          r.redir = 1'b1;
          r.target = csr_st.dpc;
        end
      end
      KIND_TICK: begin
        if (!csr_st.inhibit[0] || csr_st.dbg_mode) csr_st.cycles++;
        if ((!csr_st.inhibit[1] || csr_st.dbg_mode) && c.ret) csr_st.retired++;
        csr_st.ext_smp = c.ext;
        csr_st.sw_smp = c.sw;
        csr_st.tmr_smp = c.tmr;
      end
      default: ;
    endcase
    r.pend = irq_taken();
    r.code = r.pend ? irq_sel() : IRQ_NONE;
    r.mmode = csr_st.machine_priv;
    r.dmode = csr_st.dbg_mode;
    return r;
  endfunction

  task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  // request acceptance, result checking, register writes, idle watchdog
  always @(posedge clk_i) begin
    cmd_t  c;
    resp_t e;
    quiet++;
    if (rst_ni && done_o) begin
      quiet = 0;
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected result, actual read_data %h", $time, read_data_o);
        fails++;
      end else begin
        e = resp_q.pop_front();
        cmp("read_data", e.rd, read_data_o);
        cmp("redirect", e.redir, redirect_o);
        cmp("redir_pc", e.target, redir_pc_o);
        cmp("interrupt_pending", e.pend, interrupt_pending_o);
        cmp("interrupt_code", e.code, interrupt_code_o);
        cmp("machine_mode", e.mmode, machine_mode_o);
        cmp("debug_active", e.dmode, debug_active_o);
      end
    end
    if (rst_ni && psel && penable && pwrite && pready && paddr == 2'd0) begin
      quiet = 0;
      csr_st.vbase = pwdata;
    end
    if (rst_ni && start_i && !busy_o) begin
      quiet = 0;
      c = '{kind_i, csr_addr_i, operand_i, trap_pc_i, trap_cause_i, trap_is_interrupt_i,
            irq_external_i, irq_software_i, irq_timer_i, retiring_i, debug_data_in_i};
      resp_q.push_back(csr_step(c));
    end
    if (quiet >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    kind_i <= c.kind;
    csr_addr_i <= c.addr;
    operand_i <= c.op;
    trap_pc_i <= c.tpc;
    trap_cause_i <= c.cause;
    trap_is_interrupt_i <= c.is_int;
    irq_external_i <= c.ext;
    irq_software_i <= c.sw;
    irq_timer_i <= c.tmr;
    retiring_i <= c.ret;
    debug_data_in_i <= c.dbg;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [31:0] val);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 2'd0;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic cmd_t mk(logic [3:0] k, logic [11:0] a, logic [31:0] op);
    cmd_t c;
    c = '{default: '0};
    c.kind = k;
    c.addr = a;
    c.op = op;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   p;
    c.addr = ($urandom_range(99) < 88) ? csr_list[$urandom_range(34)] : 12'($urandom);
    c.op = $urandom;
    if ($urandom_range(3) == 0) c.op = $urandom_range(15) | ($urandom & 32'h0003_0000);
    c.tpc = $urandom;
    c.cause = $urandom_range(31);
    c.is_int = $urandom_range(1);
    c.ext = ($urandom_range(2) == 0) ? 32'd0 : $urandom;
    c.sw = $urandom_range(1);
    c.tmr = $urandom_range(1);
    c.ret = $urandom_range(1);
    c.dbg = $urandom;
    p = $urandom_range(99);
    if (p < 34) c.kind = KIND_READ;
    else if (p < 46) c.kind = KIND_WRITE;
    else if (p < 53) c.kind = KIND_SET;
    else if (p < 60) c.kind = KIND_CLEAR;
    else if (p < 66) c.kind = KIND_TRAP;
    else if (p < 71) c.kind = KIND_TRET;
    else if (p < 75) c.kind = KIND_DENTER;
    else if (p < 80) c.kind = KIND_RESUME;
    else if (p < 98) c.kind = KIND_TICK;
    else c.kind = 4'($urandom_range(15, 9));
    return c;
  endfunction

  initial begin
    row_t        rows[$];
    cmd_t        c;
    logic [31:0] cfg_vals[3];
    int          idle_sched[3];

    fails = 0;
    quiet = 0;
    idle_pct = 0;
    csr_st = '0;
    csr_st.machine_priv = 1'b1;
    csr_st.status = 5'b00100;
    csr_st.inhibit = 2'b11;
    csr_st.counten = 3'd5;
    csr_st.ext_ctx = 8'h40;
    rst_ni = 1'b0;
    {psel, penable, pwrite, paddr, pwdata} = '0;
    start_i = 1'b0;
    {kind_i, csr_addr_i, operand_i, trap_pc_i, trap_cause_i, trap_is_interrupt_i} = '0;
    {irq_external_i, irq_software_i, irq_timer_i, retiring_i, debug_data_in_i} = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_write(32'h8000_0101);

    rows.push_back('{mk(KIND_READ, CSR_MISA, 0), 1'b1, MISA_VAL});
    rows.push_back('{mk(KIND_READ, CSR_MSTATUS, 0), 1'b1, 32'h0000_1800});
    rows.push_back('{mk(KIND_READ, CSR_MCOUNTIN, 0), 1'b1, 32'd5});
    rows.push_back('{mk(KIND_READ, CSR_MVENDOR, 0), 1'b1, VENDOR_VAL});
    rows.push_back('{mk(KIND_READ, 12'hFFF, 32'hffff_ffff), 1'b1, 32'd0});
    rows.push_back('{mk(KIND_READ, CSR_TVEC, 0), 1'b1, 32'h8000_0101});
    c = mk(KIND_READ, CSR_DDATA, 0);
    c.dbg = 32'hffff_ffff;
    rows.push_back('{c, 1'b1, 32'hffff_ffff});
    rows.push_back('{mk(KIND_WRITE, CSR_MCOUNTIN, 0), 1'b0, 0});
    rows.push_back('{mk(KIND_WRITE, CSR_MIE, 32'hffff_ffff), 1'b0, 0});
    rows.push_back('{mk(KIND_WRITE, CSR_MSTATUS, 32'h8), 1'b0, 0});
    c = mk(KIND_TICK, 0, 0);
    c.ext = 32'hffff_ffff;
    {c.sw, c.tmr, c.ret} = 3'b111;
    rows.push_back('{c, 1'b0, 0});
    rows.push_back('{mk(KIND_WRITE, CSR_EXTEN, 32'hffff_0000), 1'b0, 0});
    rows.push_back('{mk(KIND_WRITE, CSR_EXTFORCE, 32'h0005_0001), 1'b0, 0});
    rows.push_back('{mk(KIND_READ, CSR_EXTCLAIM, 0), 1'b0, 0});
    rows.push_back('{mk(KIND_SET, CSR_EXTCTX, 32'h2), 1'b0, 0});
    c = mk(KIND_TRAP, 0, 0);
    c.tpc = 32'hffff_ffff;
    c.cause = 5'd11;
    c.is_int = 1'b1;
    rows.push_back('{c, 1'b0, 0});
    rows.push_back('{mk(KIND_READ, CSR_MCAUSE, 0), 1'b0, 0});
    rows.push_back('{mk(KIND_TRET, 0, 0), 1'b0, 0});
    c = mk(KIND_DENTER, 0, 0);
    c.cause = 5'd31;
    c.tpc = 32'hffff_ffff;
    rows.push_back('{c, 1'b0, 0});
    rows.push_back('{mk(KIND_WRITE, CSR_DCSR, 32'hffff_ffff), 1'b0, 0});
    rows.push_back('{mk(KIND_WRITE, CSR_DPC, 32'hffff_ffff), 1'b0, 0});
    rows.push_back('{mk(KIND_RESUME, 0, 0), 1'b0, 0});
    rows.push_back('{mk(KIND_CLEAR, CSR_MSTATUS, 32'hffff_ffff), 1'b0, 0});
    rows.push_back('{mk(4'd15, CSR_MISA, 32'hffff_ffff), 1'b0, 0});
    rows.push_back('{mk(KIND_READ, CSR_DCSR, 0), 1'b0, 0});

    foreach (rows[i]) begin
      send(rows[i].c);
      if (rows[i].chk) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        cmp("read_data (table)", rows[i].rd, read_data_o);
      end
    end

    cfg_vals = '{32'hffff_ffff, 32'h0, $urandom | 32'd1};
    idle_sched = '{31, 74, 0};
    for (int ph = 0; ph < 3; ph++) begin
      apb_write(cfg_vals[ph]);
      idle_pct = idle_sched[ph];
      for (int n = 0; n < 130; n++) begin
        // hold off new requests until everything outstanding has returned
        if (n == 60 || $urandom_range(99) == 0) drain();
        send(rand_cmd());
      end
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
